/* sv/ccsb_pkg.sv */
// ----------------------------------------------------------------------------
// ccsb_pkg: shared definitions for the character-cell sprite blitter
// Command codes, field widths and the fixed character and cursor constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ccsb_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_CHAR  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned COORD_W  = 10;
  localparam int unsigned RROW_W   = 5;
  localparam int unsigned RCOL_W   = 7;
  localparam int unsigned IN_DATA_W = 2 * COORD_W + CHAR_W + RROW_W + RCOL_W;

  localparam logic [CHAR_W-1:0]         CELL_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0]         CODE_NEWLINE = 8'd10;
  localparam logic signed [COORD_W-1:0] CURSOR_MAX   = 10'sd511;

endpackage

`default_nettype wire

/* sv/char_cell_sprite_blitter_unit.sv */
// ----------------------------------------------------------------------------
// char_cell_sprite_blitter_unit: character-cell frame store with sprite drawing
// Draws color-keyed sprite characters into a frame store, reads single cells
// and clears the whole store with spaces.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  --------  ---------  -----------------------------------------------------
//  s_axis    in         tuser: command; tdata: origin_x, origin_y, char_code,
//                       read_row, read_col
//  m_axis    out        tdata: cell_char (one transfer per read command)
//  cfg       in         cfg_wdata: transparent key, written when cfg_we is high
//
//  A character or a read command uses at most one access of the single-port
//  frame memory. A read result passes through the memory read register and
//  then the output register on its way to m_axis. A clear command, and reset,
//  start a sweep over all SCREEN_WIDTH*SCREEN_HEIGHT cells that writes one
//  cell a cycle, and s_axis_tready stays low until it ends. One finished read
//  result waits in the output register and one more in the memory read
//  register; a further input transfer stalls only while both are held. Reset
//  (rst, synchronous) clears the cursor and the handshake state and sets the
//  key to a space.
//
`default_nettype none

module char_cell_sprite_blitter_unit #(
  parameter int unsigned SCREEN_WIDTH  = 80,
  parameter int unsigned SCREEN_HEIGHT = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [9:0] origin_x, [19:10] origin_y, [27:20] char_code,
  // [32:28] read_row, [39:33] read_col
  input  wire logic [ccsb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [1:0] command
  input  wire logic [ccsb_pkg::CMD_W-1:0]         s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [7:0] cell_char
  output logic [ccsb_pkg::CHAR_W-1:0]             m_axis_tdata,
  input  wire logic                               cfg_we,
  input  wire logic [ccsb_pkg::CHAR_W-1:0]        cfg_wdata
);
  import ccsb_pkg::*;

  localparam int unsigned DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0]      LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [AW-1:0]      WIDTH_A   = AW'(SCREEN_WIDTH);
  localparam logic [COORD_W-1:0] ROW_LIM   = COORD_W'(SCREEN_HEIGHT);
  localparam logic [COORD_W-1:0] COL_LIM   = COORD_W'(SCREEN_WIDTH);
  localparam logic [7:0]         RROW_LIM  = 8'(SCREEN_HEIGHT);
  localparam logic [8:0]         RCOL_LIM  = 9'(SCREEN_WIDTH);

  typedef enum logic {ST_SWEEP, ST_RUN} state_t;

  state_t                     state;
  logic [AW-1:0]              sweep_cnt;
  logic [CHAR_W-1:0]          key;
  logic signed [COORD_W-1:0]  cursor_row;
  logic signed [COORD_W-1:0]  cursor_col;
  logic signed [COORD_W-1:0]  sprite_left;
  logic                       rd_pend;
  logic                       rd_oob;

  logic [CHAR_W-1:0]          mem [DEPTH];
  logic [CHAR_W-1:0]          mem_rdata;
  logic                       mem_we;
  logic                       mem_re;
  logic [AW-1:0]              mem_addr;
  logic [CHAR_W-1:0]          mem_wdata;

  cmd_t                       cmd;
  logic signed [COORD_W-1:0]  origin_x;
  logic signed [COORD_W-1:0]  origin_y;
  logic [CHAR_W-1:0]          char_code;
  logic [RROW_W-1:0]          read_row;
  logic [RCOL_W-1:0]          read_col;

  logic in_xfer;
  logic out_free;
  logic cursor_in_win;
  logic read_in_win;
  logic draw_we;
  logic out_load;
  logic [AW-1:0] draw_addr;
  logic [AW-1:0] read_addr;

  assign cmd       = cmd_t'(s_axis_tuser);
  assign origin_x  = s_axis_tdata[9:0];
  assign origin_y  = s_axis_tdata[19:10];
  assign char_code = s_axis_tdata[27:20];
  assign read_row  = s_axis_tdata[32:28];
  assign read_col  = s_axis_tdata[39:33];

  // A held read result drains at the same edge that a new transfer lands.
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = rd_pend && out_free;
  assign s_axis_tready = (state == ST_RUN) && (!rd_pend || out_free);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign cursor_in_win = !cursor_row[COORD_W-1] && ($unsigned(cursor_row) < ROW_LIM) &&
                         !cursor_col[COORD_W-1] && ($unsigned(cursor_col) < COL_LIM);
  assign read_in_win   = ({3'b000, read_row} < RROW_LIM) && ({2'b00, read_col} < RCOL_LIM);

  assign draw_we = in_xfer && (cmd == CMD_CHAR) && (char_code != CODE_NEWLINE) &&
                   (char_code != key) && cursor_in_win;

  assign draw_addr = AW'($unsigned(cursor_row)) * WIDTH_A + AW'($unsigned(cursor_col));
  assign read_addr = AW'(read_row) * WIDTH_A + AW'(read_col);

  assign mem_re = in_xfer && (cmd == CMD_READ) && read_in_win;

  always_comb begin
    if (state == ST_SWEEP) begin
      mem_we    = 1'b1;
      mem_addr  = sweep_cnt;
      mem_wdata = CELL_SPACE;
    end else begin
      mem_we    = draw_we;
      mem_addr  = mem_re ? read_addr : draw_addr;
      mem_wdata = char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_addr];
    end
  end

  function automatic logic signed [COORD_W-1:0] step_sat(input logic signed [COORD_W-1:0] v);
    step_sat = (v == CURSOR_MAX) ? v : v + 10'sd1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SWEEP;
      sweep_cnt     <= '0;
      key           <= CELL_SPACE;
      cursor_row    <= '0;
      cursor_col    <= '0;
      sprite_left   <= '0;
      rd_pend       <= 1'b0;
      rd_oob        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        key <= cfg_wdata;
      end

      unique case (state)
        ST_SWEEP: begin
          sweep_cnt <= sweep_cnt + AW'(1);
          if (sweep_cnt == LAST_ADDR) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (in_xfer && (cmd == CMD_CLEAR)) begin
            state     <= ST_SWEEP;
            sweep_cnt <= '0;
          end
        end
        default: state <= ST_SWEEP;
      endcase

      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= rd_oob ? CELL_SPACE : mem_rdata;
        rd_pend       <= 1'b0;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      if (in_xfer) begin
        unique case (cmd)
          CMD_BEGIN: begin
            sprite_left <= origin_x;
            cursor_col  <= origin_x;
            cursor_row  <= origin_y;
          end
          CMD_CHAR: begin
            if (char_code == CODE_NEWLINE) begin
              cursor_row <= step_sat(cursor_row);
              cursor_col <= sprite_left;
            end else begin
              cursor_col <= step_sat(cursor_col);
            end
          end
          CMD_READ: begin
            rd_pend <= 1'b1;
            rd_oob  <= !read_in_win;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // A result only appears after a read transfer has been taken.
  a_out_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(rd_pend))
    else $error("result without a pending read");

  // A pending read is never dropped while the output register is held.
  a_pend_holds: assert property (@(posedge clk) disable iff (rst)
    (rd_pend && !out_free) |=> rd_pend)
    else $error("pending read lost");

  // The single memory port never reads and writes in one cycle.
  a_one_access: assert property (@(posedge clk) disable iff (rst)
    mem_re |-> !mem_we)
    else $error("memory read and write collide");

  // An accepted read leaves a pending result behind.
  a_read_pends: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (cmd == CMD_READ)) |=> rd_pend)
    else $error("read transfer not tracked");

  // The sweep starts right after a clear transfer.
  a_clear_sweeps: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (cmd == CMD_CLEAR)) |=> (state == ST_SWEEP) && (sweep_cnt == '0))
    else $error("clear did not start a sweep");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for char_cell_sprite_blitter_unit
// Drives clear, begin, sprite character and cell read commands with random
// gaps and stalls, predicts every cell read from its own copy of the frame
// store and cursor, and runs under several transparent keys.
// ----------------------------------------------------------------------------
module testbench;
  import ccsb_pkg::*;

  localparam int SCREEN_W = 80;
  localparam int SCREEN_H = 32;
  localparam int IDLE_LIMIT = 12000;
  localparam int HOLD_CYCLES = 400;
  localparam int RUN_ITEMS = 380;

  typedef struct {
    cmd_t               cmd;
    logic signed [9:0]  origin_x;
    logic signed [9:0]  origin_y;
    logic [7:0]         char_code;
    logic [4:0]         read_row;
    logic [6:0]         read_col;
  } blit_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // [9:0] origin_x, [19:10] origin_y, [27:20] char_code,
  // [32:28] read_row, [39:33] read_col
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  // [1:0] command
  logic [CMD_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // [7:0] cell_char
  logic [CHAR_W-1:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [CHAR_W-1:0] cfg_wdata = '0;

  char_cell_sprite_blitter_unit #(
    .SCREEN_WIDTH(SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted block state.
  logic [7:0]        screen_cells [SCREEN_W*SCREEN_H];
  logic signed [9:0] pen_row;
  logic signed [9:0] pen_col;
  logic signed [9:0] sprite_left_col;
  logic [7:0]        key_char = CELL_SPACE;

  blit_item_t  pend_q[$];
  logic [7:0]  cell_expect_q[$];
  blit_item_t  held_item;
  logic [7:0]  want_char;

  int send_gap;
  int recv_stall;
  int hold_left;
  int hold_seen;
  int hold_req_cnt = 0;
  logic send_idle_on = 1'b1;
  logic recv_idle_on = 1'b1;
  int idle_cycles;
  int fail_count;
  int n_accepted;
  int n_checked;
  int n_clears;
  int n_keys;

  function automatic logic signed [9:0] cursor_step(logic signed [9:0] v);
    return (v >= CURSOR_MAX) ? CURSOR_MAX : v + 10'sd1;
  endfunction

  function automatic int pick_gap(logic enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic blit_predict(blit_item_t it);
    case (it.cmd)
      CMD_CLEAR: begin
        foreach (screen_cells[i]) screen_cells[i] = CELL_SPACE;
        n_clears++;
      end
      CMD_BEGIN: begin
        sprite_left_col = it.origin_x;
        pen_col = it.origin_x;
        pen_row = it.origin_y;
      end
      CMD_CHAR: begin
        if (it.char_code == CODE_NEWLINE) begin
          // Newline wins even when it equals the transparent key.
          pen_row = cursor_step(pen_row);
          pen_col = sprite_left_col;
        end else begin
          if (int'(pen_row) >= 0 && int'(pen_row) < SCREEN_H &&
              int'(pen_col) >= 0 && int'(pen_col) < SCREEN_W &&
              it.char_code != key_char)
            screen_cells[int'(pen_row) * SCREEN_W + int'(pen_col)] = it.char_code;
          pen_col = cursor_step(pen_col);
        end
      end
      CMD_READ: begin
        if (int'(it.read_row) < SCREEN_H && int'(it.read_col) < SCREEN_W)
          cell_expect_q.push_back(screen_cells[int'(it.read_row) * SCREEN_W + int'(it.read_col)]);
        else
          cell_expect_q.push_back(CELL_SPACE);
      end
    endcase
  endtask

  task automatic queue_item(cmd_t c, int ox, int oy, int code, int rr, int rc);
    blit_item_t it;
    it.cmd = c;
    it.origin_x = 10'(ox);
    it.origin_y = 10'(oy);
    it.char_code = 8'(code);
    it.read_row = 5'(rr);
    it.read_col = 7'(rc);
    pend_q.push_back(it);
  endtask

  // One begin, a run of sprite characters and a few reads, with noise in the
  // fields that each command ignores; at times a lone clear or random command instead.
  task automatic gen_sprite_run(output int n);
    int x, y, len, nrd, code, r, c, pick;
    n = 0;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      queue_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
      n = 1;
      return;
    end
    if (pick < 8) begin
      queue_item(cmd_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                 $urandom);
      n = 1;
      return;
    end
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      x = int'($urandom_range(0, 1023)) - 512;
      y = int'($urandom_range(0, 1023)) - 512;
    end else if (pick < 15) begin
      x = $urandom_range(495, 511);
      y = $urandom_range(500, 511);
    end else begin
      x = int'($urandom_range(0, 99)) - 12;
      y = int'($urandom_range(0, 43)) - 6;
    end
    queue_item(CMD_BEGIN, x, y, $urandom, $urandom, $urandom);
    len = $urandom_range(1, 20);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) code = int'(CODE_NEWLINE);
      else if (pick < 30) code = int'(key_char);
      else if (pick < 45) code = $urandom_range(0, 255);
      else code = $urandom_range(33, 126);
      queue_item(CMD_CHAR, $urandom, $urandom, code, $urandom, $urandom);
    end
    nrd = $urandom_range(0, 5);
    for (int i = 0; i < nrd; i++) begin
      if ($urandom_range(0, 1) == 1) begin
        r = (y + int'($urandom_range(0, 3))) & 31;
        c = x + int'($urandom_range(0, 12));
        if (c < 0 || c > 127) c = $urandom_range(0, 127);
      end else begin
        r = $urandom_range(0, 31);
        c = $urandom_range(0, 127);
      end
      queue_item(CMD_READ, $urandom, $urandom, $urandom, r, c);
    end
    n = 2 + len + nrd - 1;
  endtask

  // Waits until every item has gone in, every read has come back and the
  // block accepts input again, so that the key may be changed safely.
  task automatic wait_quiet();
    @(negedge clk);
    while (pend_q.size() != 0 || s_axis_tvalid || cell_expect_q.size() != 0)
      @(negedge clk);
    repeat (6) @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
  endtask

  task automatic write_key(logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    key_char = v;
    n_keys++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Sender: presents queued items and updates the prediction on each transfer.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
      foreach (screen_cells[i]) screen_cells[i] = CELL_SPACE;
      pen_row = '0;
      pen_col = '0;
      sprite_left_col = '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        blit_predict(held_item);
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          held_item = pend_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {held_item.read_col, held_item.read_row, held_item.char_code,
                           held_item.origin_y, held_item.origin_x};
          s_axis_tuser <= held_item.cmd;
          send_gap = pick_gap(send_idle_on);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_stall = 0;
      hold_left = 0;
      hold_seen = 0;
    end else if (hold_seen != hold_req_cnt) begin
      hold_seen = hold_req_cnt;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      recv_stall = pick_gap(recv_idle_on);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (cell_expect_q.size() == 0) begin
        $error("cell_char: unexpected result %0d with no read outstanding", m_axis_tdata);
        fail_count++;
      end else begin
        want_char = cell_expect_q.pop_front();
        n_checked++;
        if (m_axis_tdata !== want_char) begin
          $error("cell_char: expected %0d, actual %0d", want_char, m_axis_tdata);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int got;
    int queued;
    logic [7:0] phase_key [5];
    phase_key[0] = 8'd0;
    phase_key[1] = 8'd255;
    phase_key[2] = CODE_NEWLINE;
    phase_key[3] = 8'($urandom_range(0, 255));
    phase_key[4] = CELL_SPACE;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait_quiet();
    write_key(CELL_SPACE);

    // Directed: drawing before begin, code zero, the key, clipping on every
    // edge, saturation at the cursor limit, out-of-window reads, clear.
    queue_item(CMD_READ, 0, 0, 0, 0, 0);
    queue_item(CMD_CHAR, 0, 0, 65, 0, 0);
    queue_item(CMD_CHAR, 0, 0, 0, 0, 0);
    queue_item(CMD_CHAR, 0, 0, int'(CELL_SPACE), 0, 0);
    queue_item(CMD_READ, 0, 0, 0, 0, 0);
    queue_item(CMD_READ, 0, 0, 0, 0, 1);
    queue_item(CMD_BEGIN, 78, 31, 0, 0, 0);
    queue_item(CMD_CHAR, 0, 0, 66, 0, 0);
    queue_item(CMD_CHAR, 0, 0, 67, 0, 0);
    queue_item(CMD_CHAR, 0, 0, 68, 0, 0);
    queue_item(CMD_CHAR, 0, 0, int'(CODE_NEWLINE), 0, 0);
    queue_item(CMD_BEGIN, -2, -1, 0, 0, 0);
    queue_item(CMD_CHAR, 0, 0, 70, 0, 0);
    queue_item(CMD_CHAR, 0, 0, int'(CODE_NEWLINE), 0, 0);
    queue_item(CMD_CHAR, 0, 0, 71, 0, 0);
    queue_item(CMD_CHAR, 0, 0, 72, 0, 0);
    queue_item(CMD_CHAR, 0, 0, 73, 0, 0);
    queue_item(CMD_BEGIN, 511, 511, 0, 0, 0);
    queue_item(CMD_CHAR, 0, 0, 74, 0, 0);
    queue_item(CMD_CHAR, 0, 0, int'(CODE_NEWLINE), 0, 0);
    queue_item(CMD_BEGIN, -512, -512, 255, 0, 0);
    queue_item(CMD_READ, 0, 0, 0, 0, 0);
    queue_item(CMD_READ, 0, 0, 0, 31, 79);
    queue_item(CMD_READ, 0, 0, 0, 5, 127);
    queue_item(CMD_CLEAR, 0, 0, 0, 0, 0);
    queue_item(CMD_READ, 0, 0, 0, 31, 79);

    for (int ph = 0; ph < 5; ph++) begin
      wait_quiet();
      write_key(phase_key[ph]);
      // The second phase runs back to back with no idling on either side.
      send_idle_on <= (ph != 1);
      recv_idle_on <= (ph != 1);
      queued = 0;
      if (ph == 2) begin
        // Long receiver hold-off while reads keep coming, so the output
        // fills and the input stalls.
        hold_req_cnt <= hold_req_cnt + 1;
        for (int i = 0; i < 40; i++)
          queue_item(CMD_READ, $urandom, $urandom, $urandom, $urandom_range(0, 31),
                     $urandom_range(0, 127));
        queued = 40;
      end
      while (queued < RUN_ITEMS) begin
        gen_sprite_run(got);
        queued += got;
      end
    end

    wait_quiet();
    repeat (20) @(negedge clk);
    $display("Covered %0d commands under %0d key settings: %0d cell reads compared,",
             n_accepted, n_keys, n_checked);
    $display("%0d store clears, clipping on all edges and cursor saturation.", n_clears);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* char_cell_sprite_blitter_unit.f */
sv/ccsb_pkg.sv
sv/char_cell_sprite_blitter_unit.sv
bench/testbench.sv
